@@ rtl/core/lbsm_pkg.sv @@
// ----------------------------------------------------------------------------
// lbsm_pkg
// Shared widths, register indexes and controller/datapath interface types
// for the ambient light to brightness square-root curve.
// ----------------------------------------------------------------------------
package lbsm_pkg;

  localparam int unsigned LIGHT_BITS = 16;
  localparam int unsigned LEVEL_W    = 7;
  localparam int unsigned FS_W       = 16;
  localparam int unsigned SCALE_W    = 10;
  localparam int unsigned DIVD_W     = LIGHT_BITS + SCALE_W;
  localparam int unsigned NORM_W     = 10;
  localparam int unsigned ROOT_W     = 5;
  localparam int unsigned PROD_W     = ROOT_W + LEVEL_W;
  localparam int unsigned CMP_W      = (LIGHT_BITS > FS_W) ? LIGHT_BITS : FS_W;
  localparam int unsigned CNT_W      = $clog2(DIVD_W);

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [SCALE_W-1:0] NormScale = SCALE_W'(1000);
  localparam logic [CNT_W-1:0]   DivLast   = CNT_W'(DIVD_W - 1);
  localparam logic [CNT_W-1:0]   RootLast  = CNT_W'(ROOT_W - 1);

  localparam logic [CFG_IDX_W-1:0] RegMinLevel  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] RegMaxLevel  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] RegFullScale = CFG_IDX_W'(2);

  localparam logic [LEVEL_W-1:0] MinLevelReset  = LEVEL_W'(5);
  localparam logic [LEVEL_W-1:0] MaxLevelReset  = LEVEL_W'(100);
  localparam logic [FS_W-1:0]    FullScaleReset = FS_W'(500);

  typedef struct packed {
    logic load;       // capture sample, start divide
    logic div_step;   // one restoring divide step
    logic root_step;  // one square-root bit decision
    logic mul;        // root times span
    logic add;        // scaled root plus minimum into result
    logic take_max;   // result is the maximum level
  } lbsm_cmd_t;

  typedef struct packed {
    logic saturate;   // sample at or above full scale
  } lbsm_status_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MAX  = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_ROOT = 7'b0001000,
    S_MUL  = 7'b0010000,
    S_ADD  = 7'b0100000,
    S_OUT  = 7'b1000000
  } lbsm_state_e;

endpackage

@@ rtl/core/light_to_brightness_sqrt_map.sv @@
// ----------------------------------------------------------------------------
// light_to_brightness_sqrt_map
// Ambient light reading to backlight brightness percentage on a square-root
// curve between a programmable minimum and maximum level.
// ----------------------------------------------------------------------------
// A reading is taken when start_i is high and busy_o is low. A reading at or
// above full scale (or any reading when full scale is zero) returns
// max_level by way of S_MAX, with done_o high in S_OUT. Any other reading
// goes through a restoring divider that resolves one quotient bit per cycle
// over the 26-bit normalized product, then 5 square-root steps, a multiply and
// an add, after which the S_OUT state raises done_o. done_o is high for one cycle
// with brightness_pct_o valid; the receiver cannot stall it, and busy_o falls
// in the following cycle. One reading is in flight at a time. Config writes
// are always ready and should only be made while busy_o is low; unknown
// register indexes are ignored.
module light_to_brightness_sqrt_map (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [lbsm_pkg::LIGHT_BITS-1:0]     light_sample_i,
  output logic                                done_o,
  output logic [lbsm_pkg::LEVEL_W-1:0]        brightness_pct_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lbsm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lbsm_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import lbsm_pkg::*;

  logic [LEVEL_W-1:0] min_level_q;
  logic [LEVEL_W-1:0] max_level_q;
  logic [FS_W-1:0]    full_scale_q;
  logic               cfg_we;
  lbsm_cmd_t          cmd;
  lbsm_status_t       status;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_level_q  <= MinLevelReset;
      max_level_q  <= MaxLevelReset;
      full_scale_q <= FullScaleReset;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        RegMinLevel:  min_level_q  <= cfg_data_i[LEVEL_W-1:0];
        RegMaxLevel:  max_level_q  <= cfg_data_i[LEVEL_W-1:0];
        RegFullScale: full_scale_q <= cfg_data_i[FS_W-1:0];
        default: ;
      endcase
    end
  end

  lbsm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  lbsm_dp u_dp (
    .clk_i              (clk_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .light_sample_i     (light_sample_i),
    .min_level_i        (min_level_q),
    .max_level_i        (max_level_q),
    .full_scale_light_i (full_scale_q),
    .brightness_pct_o   (brightness_pct_o)
  );

endmodule

@@ rtl/core/lbsm_ctrl.sv @@
// ----------------------------------------------------------------------------
// lbsm_ctrl
// Sequencer: saturation bypass, divide steps, root steps, scale, result strobe.
// ----------------------------------------------------------------------------
module lbsm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  lbsm_pkg::lbsm_status_t status_i,
  output lbsm_pkg::lbsm_cmd_t    cmd_o,
  output logic                  busy_o,
  output logic                  done_o
);
  import lbsm_pkg::*;

  lbsm_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = DivLast;
          state_d    = status_i.saturate ? S_MAX : S_DIV;
        end
      end
      S_MAX: begin
        cmd_o.take_max = 1'b1;
        state_d        = S_OUT;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          cnt_d   = RootLast;
          state_d = S_ROOT;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      S_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_MUL;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ADD;
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_OUT);

endmodule

@@ rtl/core/lbsm_dp.sv @@
// ----------------------------------------------------------------------------
// lbsm_dp
// Datapath: normalize multiply, restoring divider, bitwise square root,
// span scaling and result register.
// ----------------------------------------------------------------------------
module lbsm_dp (
  input  logic                              clk_i,
  input  lbsm_pkg::lbsm_cmd_t               cmd_i,
  output lbsm_pkg::lbsm_status_t            status_o,
  input  logic [lbsm_pkg::LIGHT_BITS-1:0]   light_sample_i,
  input  logic [lbsm_pkg::LEVEL_W-1:0]      min_level_i,
  input  logic [lbsm_pkg::LEVEL_W-1:0]      max_level_i,
  input  logic [lbsm_pkg::FS_W-1:0]         full_scale_light_i,
  output logic [lbsm_pkg::LEVEL_W-1:0]      brightness_pct_o
);
  import lbsm_pkg::*;

  logic [DIVD_W-1:0]  quo_q;      // dividend shifts out, quotient shifts in
  logic [FS_W-1:0]    rem_q;
  logic [ROOT_W-1:0]  root_q;
  logic [ROOT_W-1:0]  mask_q;
  logic [PROD_W-1:0]  prod_q;
  logic [LEVEL_W-1:0] result_q;

  logic [FS_W:0]       rem_shift;
  logic                rem_ge;
  logic [FS_W-1:0]     rem_sub;
  logic [ROOT_W-1:0]   trial;
  logic [2*ROOT_W-1:0] trial_sq;
  logic [NORM_W-1:0]   norm;
  logic [LEVEL_W-1:0]  span;
  logic [LEVEL_W-1:0]  sum;

  assign status_o.saturate = (CMP_W'(light_sample_i) >= CMP_W'(full_scale_light_i));

  assign rem_shift = {rem_q, quo_q[DIVD_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, full_scale_light_i});
  // difference is below full scale whenever it is taken
  assign rem_sub   = rem_shift[FS_W-1:0] - full_scale_light_i;

  // quotient stays below 1000 since the sample is below full scale
  assign norm     = quo_q[NORM_W-1:0];
  assign trial    = root_q | mask_q;
  assign trial_sq = (2*ROOT_W)'(trial) * (2*ROOT_W)'(trial);

  assign span = (max_level_i >= min_level_i) ? (max_level_i - min_level_i) : '0;
  assign sum  = min_level_i + prod_q[PROD_W-1 -: LEVEL_W];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      quo_q  <= DIVD_W'(light_sample_i) * DIVD_W'(NormScale);
      rem_q  <= '0;
      root_q <= '0;
      mask_q <= {1'b1, {(ROOT_W-1){1'b0}}};
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_ge ? rem_sub : rem_shift[FS_W-1:0];
      quo_q <= {quo_q[DIVD_W-2:0], rem_ge};
    end
    if (cmd_i.root_step) begin
      if (trial_sq <= norm) begin
        root_q <= trial;
      end
      mask_q <= mask_q >> 1;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(root_q) * PROD_W'(span);
    end
    if (cmd_i.add) begin
      result_q <= sum;
    end
    if (cmd_i.take_max) begin
      result_q <= max_level_i;
    end
  end

  assign brightness_pct_o = result_q;

endmodule
